/* rtl/tvln_pkg.sv */
`default_nettype none

package tvln_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 1;
    localparam int BODY_MAX          = 4;

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL   = 8'h40;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HI_NL  = 8'h8A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_LINES    = 3'd0,
        CFG_NUMBER_NONBLANK = 3'd1,
        CFG_SHOW_ENDS       = 3'd2,
        CFG_SQUEEZE_BLANK   = 3'd3,
        CFG_SHOW_TABS       = 3'd4,
        CFG_SHOW_NONPRINT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic number_lines;
        logic number_nonblank_only;
        logic show_ends;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_file;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_NUMBER,
        PFX_BLANK
    } t_pfx;

    // one classified item; the line number digits travel next to it
    typedef struct packed {
        t_pfx                      pfx;
        logic [BODY_MAX-1:0][7:0]  body;
        logic [2:0]                body_len;
    } t_desc;

endpackage

`default_nettype wire

/* rtl/tvln_front.sv */
`default_nettype none

module tvln_front import tvln_pkg::*; #(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  t_cfg                      i_cfg,
    input  wire                       i_valid,
    input  t_in                       i_data,
    input  wire                       i_full,
    output logic                      o_stall,
    output logic                      o_push,
    output t_desc                     o_desc,
    output logic [4*NUMBER_DIGITS-1:0] o_digits
);

    localparam int CW = 4 * NUMBER_DIGITS;

    logic          r_at_line_start, n_at_line_start;
    logic          r_blank_gobbled, n_blank_gobbled;
    logic [CW-1:0] r_count, n_count;

    logic          accept;
    logic          als, bg;
    logic [CW-1:0] cnt, cnt_inc;
    logic [7:0]    ch;
    logic [6:0]    c7;
    logic          is_nl, is_tab, squeezed, do_num, do_blank, all_nines, carry;
    logic [3:0]    d;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    assign ch     = i_data.in_byte;
    assign c7     = ch[6:0];
    assign is_nl  = (ch == CH_NL);
    assign is_tab = (ch == CH_TAB);

    // a new file restarts line state before this byte
    assign als = i_data.first_of_file ? 1'b1 : r_at_line_start;
    assign bg  = i_data.first_of_file ? 1'b0 : r_blank_gobbled;
    assign cnt = i_data.first_of_file ? '0 : r_count;

    assign squeezed = als && i_cfg.squeeze_blank && is_nl && bg;
    assign do_num   = als && !squeezed && i_cfg.number_lines &&
                      (!i_cfg.number_nonblank_only || !is_nl);
    assign do_blank = als && i_cfg.number_lines && i_cfg.number_nonblank_only &&
                      is_nl && i_cfg.show_ends;

    // BCD increment, holding at all nines
    always_comb begin
        cnt_inc   = cnt;
        all_nines = 1'b1;
        carry     = 1'b1;
        d         = '0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = cnt[4*i +: 4];
            if (d != 4'd9) all_nines = 1'b0;
            if (carry) begin
                if (d == 4'd9) begin
                    cnt_inc[4*i +: 4] = 4'd0;
                end else begin
                    cnt_inc[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines) cnt_inc = cnt;
    end

    always_comb begin
        n_count         = do_num ? cnt_inc : cnt;
        n_blank_gobbled = als && i_cfg.squeeze_blank && is_nl;
        // line start follows the byte after the high bit is stripped
        n_at_line_start = is_nl || (i_cfg.show_nonprinting && ch == CH_HI_NL);
    end

    always_comb begin
        o_desc          = '0;
        o_desc.pfx      = do_num ? PFX_NUMBER : (do_blank ? PFX_BLANK : PFX_NONE);
        o_desc.body[0]  = ch;
        o_desc.body_len = 3'd1;
        if (is_nl) begin
            if (i_cfg.show_ends) begin
                o_desc.body[0]  = CH_DOLLAR;
                o_desc.body[1]  = CH_NL;
                o_desc.body_len = 3'd2;
            end
        end else if (is_tab) begin
            if (i_cfg.show_tabs) begin
                o_desc.body[0]  = CH_CARET;
                o_desc.body[1]  = CH_I;
                o_desc.body_len = 3'd2;
            end
        end else if (i_cfg.show_nonprinting) begin
            if (c7 < 7'h20 || c7 == CH_DEL[6:0]) begin
                if (ch[7]) begin
                    o_desc.body[0]  = CH_M;
                    o_desc.body[1]  = CH_DASH;
                    o_desc.body[2]  = CH_CARET;
                    o_desc.body[3]  = (c7 == CH_DEL[6:0]) ? CH_QMARK : ({1'b0, c7} | CH_CTRL);
                    o_desc.body_len = 3'd4;
                end else begin
                    o_desc.body[0]  = CH_CARET;
                    o_desc.body[1]  = (c7 == CH_DEL[6:0]) ? CH_QMARK : ({1'b0, c7} | CH_CTRL);
                    o_desc.body_len = 3'd2;
                end
            end else if (ch[7]) begin
                o_desc.body[0]  = CH_M;
                o_desc.body[1]  = CH_DASH;
                o_desc.body[2]  = {1'b0, c7};
                o_desc.body_len = 3'd3;
            end
        end
    end

    assign o_digits = n_count;
    assign o_push   = accept && !squeezed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_blank_gobbled <= 1'b0;
            r_count         <= '0;
        end else if (accept) begin
            r_at_line_start <= n_at_line_start;
            r_blank_gobbled <= n_blank_gobbled;
            r_count         <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/tvln_queue.sv */
`default_nettype none

module tvln_queue import tvln_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL = NW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/tvln_back.sv */
`default_nettype none

module tvln_back import tvln_pkg::*; #(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_q_valid,
    input  t_desc                      i_desc,
    input  wire [4*NUMBER_DIGITS-1:0]  i_digits,
    output logic                       o_pop,
    output logic                       o_valid,
    output t_out                       o_data,
    input  wire                        i_stall
);

    localparam int PW = (NUMBER_DIGITS + 1 > BODY_MAX) ? $clog2(NUMBER_DIGITS + 1)
                                                       : $clog2(BODY_MAX);
    localparam int LW = (PW > 3) ? PW : 3;
    localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [PW-1:0] POS_TAB = PW'(NUMBER_DIGITS);
    localparam logic [PW-1:0] TOP_DIG = PW'(NUMBER_DIGITS - 1);

    logic [PW-1:0] r_pos;
    logic          r_in_body;
    logic          r_seen;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;

    logic          in_body, load, last;
    logic [PW-1:0] di_full;
    logic [DW-1:0] di;
    logic [3:0]    d;
    logic [7:0]    nxt_byte;

    assign in_body = r_in_body || (i_desc.pfx == PFX_NONE);
    assign load    = i_q_valid && (!r_ovalid || !i_stall);
    assign di_full = TOP_DIG - r_pos;
    assign di      = di_full[DW-1:0];
    assign d       = i_digits[4*di +: 4];

    always_comb begin
        nxt_byte = CH_SPACE;
        last     = 1'b0;
        if (in_body) begin
            nxt_byte = i_desc.body[r_pos[1:0]];
            last     = (LW'(i_desc.body_len) == LW'(r_pos) + 1'b1);
        end else if (r_pos == POS_TAB) begin
            nxt_byte = CH_TAB;
        end else begin
            case (i_desc.pfx)
                PFX_NUMBER: begin
                    // blank leading zeros, but always show the units digit
                    if (d != 4'd0 || r_seen || di_full == '0) nxt_byte = CH_ZERO | {4'd0, d};
                    else                                     nxt_byte = CH_SPACE;
                end
                default: nxt_byte = CH_SPACE;
            endcase
        end
    end

    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_in_body <= 1'b0;
            r_seen    <= 1'b0;
        end else if (load) begin
            if (last) begin
                r_pos     <= '0;
                r_in_body <= 1'b0;
                r_seen    <= 1'b0;
            end else if (!in_body && r_pos == POS_TAB) begin
                r_pos     <= '0;
                r_in_body <= 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (!in_body && d != 4'd0) r_seen <= 1'b1;
            end
        end
    end

    // output register: take the next byte when the register is empty or the current one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= nxt_byte;
            r_olast <= last;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_data.out_byte    = r_obyte;
    assign o_data.last_of_run = r_olast;

endmodule

`default_nettype wire

/* rtl/text_visualize_line_number_core.sv */
// The first output byte of an item is registered in the item queue and then in the output register.
// The back end sends one output byte per cycle while the output is not stalled; an item that
// expands to N bytes (1 to NUMBER_DIGITS+5) holds it for all N, so single-byte items flow one per cycle.
// The input stalls only while the item queue between front and back end is full.
// Reset (synchronous, active low): options cleared, line start set, counter zero, queue empty.
`default_nettype none

module text_visualize_line_number_core import tvln_pkg::*; #(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_valid,
    input  t_in                   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out                  o_data,
    input  wire                   i_stall
);

    localparam int CW = 4 * NUMBER_DIGITS;
    localparam int QW = $bits(t_desc) + CW;

    t_cfg          r_cfg;
    logic          q_full, q_valid, push, pop;
    t_desc         f_desc, b_desc;
    logic [CW-1:0] f_digits, b_digits;
    logic [QW-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_LINES:    r_cfg.number_lines         <= i_cfg_data[0];
                CFG_NUMBER_NONBLANK: r_cfg.number_nonblank_only <= i_cfg_data[0];
                CFG_SHOW_ENDS:       r_cfg.show_ends            <= i_cfg_data[0];
                CFG_SQUEEZE_BLANK:   r_cfg.squeeze_blank        <= i_cfg_data[0];
                CFG_SHOW_TABS:       r_cfg.show_tabs            <= i_cfg_data[0];
                CFG_SHOW_NONPRINT:   r_cfg.show_nonprinting     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tvln_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_full   (q_full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_desc   (f_desc),
        .o_digits (f_digits)
    );

    tvln_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_desc, f_digits}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign b_desc   = t_desc'(q_rdata[QW-1:CW]);
    assign b_digits = q_rdata[CW-1:0];

    tvln_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (b_desc),
        .i_digits  (b_digits),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

`default_nettype wire

/* tb/text_visualize_line_number_core_test.sv */
`timescale 1ns / 1ps

module text_visualize_line_number_core_test;
    import tvln_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_SHOWN    = 40;

    logic           i_clk;
    logic           i_rst_n;
    logic           cfg_we;
    t_cfg_idx       cfg_idx;
    logic [0:0]     cfg_data;
    logic           src_valid;
    t_in            src_item;
    logic           o_stall;
    logic           o_valid;
    t_out           o_data;
    logic           snk_stall;

    text_visualize_line_number_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (src_valid),
        .i_data     (src_item),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (snk_stall)
    );

    // predictor state
    t_cfg                          opt;
    logic                          line_start;
    logic                          blank_seen;
    logic [4*NUMBER_DIGITS_DEF-1:0] line_bcd;

    t_in   pending[$];
    t_out  visible_q[$];
    int    bad_count;
    int    idle_run;
    logic  in_taken;
    bit    quiet;
    int    hold_asks;
    int    hold_served;
    int    tx_gap;
    int    rx_gap;
    int    hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_bad(string msg);
        bad_count++;
        if (bad_count <= MAX_SHOWN)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Work out the visible bytes that one input byte turns into.
    task automatic render_byte(t_in it);
        logic [7:0] ch;
        logic [7:0] run_b [$];
        int         i;
        bit         lead;
        bit         carry;
        logic [3:0] dg;
        t_out       r;
        ch = it.in_byte;
        if (it.first_of_file) begin
            line_bcd   = '0;
            blank_seen = 1'b0;
            line_start = 1'b1;
        end
        if (line_start) begin
            if (opt.squeeze_blank && ch == CH_NL) begin
                // repeated blank line vanishes entirely
                if (blank_seen)
                    return;
                blank_seen = 1'b1;
            end else begin
                blank_seen = 1'b0;
            end
            if (opt.number_lines) begin
                if (!opt.number_nonblank_only || ch != CH_NL) begin
                    carry = 1'b0;
                    for (i = 0; i < NUMBER_DIGITS_DEF; i++)
                        if (line_bcd[4*i +: 4] != 4'd9)
                            carry = 1'b1;
                    // saturate at all nines, else BCD increment
                    for (i = 0; i < NUMBER_DIGITS_DEF; i++) begin
                        if (carry) begin
                            if (line_bcd[4*i +: 4] == 4'd9) begin
                                line_bcd[4*i +: 4] = 4'd0;
                            end else begin
                                line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                    lead = 1'b0;
                    for (i = NUMBER_DIGITS_DEF - 1; i >= 0; i--) begin
                        dg = line_bcd[4*i +: 4];
                        if (dg != 4'd0 || lead || i == 0) begin
                            lead = 1'b1;
                            run_b.push_back(CH_ZERO + {4'd0, dg});
                        end else begin
                            run_b.push_back(CH_SPACE);
                        end
                    end
                    run_b.push_back(CH_TAB);
                end else if (opt.show_ends) begin
                    for (i = 0; i < NUMBER_DIGITS_DEF; i++)
                        run_b.push_back(CH_SPACE);
                    run_b.push_back(CH_TAB);
                end
            end
        end else begin
            blank_seen = 1'b0;
        end

        if (ch == CH_NL) begin
            if (opt.show_ends)
                run_b.push_back(CH_DOLLAR);
            run_b.push_back(ch);
        end else if (ch == CH_TAB) begin
            if (opt.show_tabs) begin
                run_b.push_back(CH_CARET);
                run_b.push_back(CH_I);
            end else begin
                run_b.push_back(ch);
            end
        end else if (opt.show_nonprinting) begin
            if (ch[7]) begin
                run_b.push_back(CH_M);
                run_b.push_back(CH_DASH);
                ch[7] = 1'b0;
            end
            if (ch < CH_SPACE || ch == CH_DEL) begin
                run_b.push_back(CH_CARET);
                run_b.push_back((ch == CH_DEL) ? CH_QMARK : (ch | CH_CTRL));
            end else begin
                run_b.push_back(ch);
            end
        end else begin
            run_b.push_back(ch);
        end
        // stripped byte decides the line start, so M-^J breaks a line
        line_start = (ch == CH_NL);

        for (i = 0; i < run_b.size(); i++) begin
            r.out_byte    = run_b[i];
            r.last_of_run = (i == run_b.size() - 1);
            visible_q.push_back(r);
        end
    endtask

    // input side: advance only after a transfer, otherwise hold the payload
    always @(negedge i_clk) begin
        if (i_rst_n && (!src_valid || in_taken)) begin
            if (tx_gap != 0) begin
                tx_gap    <= tx_gap - 1;
                src_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                tx_gap    <= $urandom_range(0, 17);
                src_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                src_item  <= pending.pop_front();
                src_valid <= 1'b1;
            end else begin
                src_valid <= 1'b0;
            end
        end
    end

    // output side stalls
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            snk_stall <= 1'b1;
        end else if (hold_asks != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
            snk_stall   <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap    <= rx_gap - 1;
            snk_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rx_gap    <= $urandom_range(0, 17);
            snk_stall <= 1'b1;
        end else begin
            snk_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        bit   in_fire;
        bit   out_fire;
        in_fire  = i_rst_n && src_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !snk_stall;
        in_taken <= in_fire;
        if (in_fire)
            render_byte(src_item);
        if (out_fire) begin
            if (visible_q.size() == 0) begin
                note_bad($sformatf("unexpected byte %02h", o_data.out_byte));
            end else begin
                want = visible_q.pop_front();
                if (o_data.out_byte !== want.out_byte)
                    note_bad($sformatf("out_byte %02h, want %02h",
                                       o_data.out_byte, want.out_byte));
                if (o_data.last_of_run !== want.last_of_run)
                    note_bad($sformatf("last_of_run %0b, want %0b (byte %02h)",
                                       o_data.last_of_run, want.last_of_run,
                                       want.out_byte));
            end
        end
        if (!i_rst_n || in_fire || out_fire)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    initial begin
        wait (idle_run >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic offer(logic [7:0] b, logic fof);
        t_in it;
        it.in_byte       = b;
        it.first_of_file = fof;
        pending.push_back(it);
    endtask

    function automatic logic [7:0] body_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      return 8'($urandom_range(8'h20, 8'h7E));
        else if (pick < 55) return CH_TAB;
        else if (pick < 64) return 8'($urandom_range(0, 31));
        else if (pick < 69) return CH_DEL;
        else if (pick < 74) return CH_HI_NL;
        else if (pick < 90) return 8'($urandom_range(8'h80, 8'hFF));
        else                return 8'($urandom_range(0, 255));
    endfunction

    // Lines of random text, with blank runs now and then for the squeeze path.
    task automatic queue_lines(int n_items, int max_len, int fof_odds);
        int left;
        int len;
        int k;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(0, max_len);
            for (k = 0; k <= len && left > 0; k++) begin
                offer((k == len) ? CH_NL : body_byte(),
                      fof_odds != 0 && $urandom_range(1, fof_odds) == 1);
                left--;
            end
            if (max_len > 1 && $urandom_range(0, 5) == 0)
                for (k = $urandom_range(1, 4); k > 0 && left > 0; k--) begin
                    offer(CH_NL, 1'b0);
                    left--;
                end
        end
    endtask

    // wait until all results are in, then let any swallowed item drain
    task automatic settle();
        do @(posedge i_clk);
        while (pending.size() != 0 || src_valid || visible_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
    endtask

    task automatic set_options(t_cfg c);
        put_reg(CFG_NUMBER_LINES, c.number_lines);
        put_reg(CFG_NUMBER_NONBLANK, c.number_nonblank_only);
        put_reg(CFG_SHOW_ENDS, c.show_ends);
        put_reg(CFG_SQUEEZE_BLANK, c.squeeze_blank);
        put_reg(CFG_SHOW_TABS, c.show_tabs);
        put_reg(CFG_SHOW_NONPRINT, c.show_nonprinting);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        opt = c;
    endtask

    initial begin : stimulus
        t_cfg c;
        int   ph;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_NUMBER_LINES;
        cfg_data    = 1'b0;
        src_valid   = 1'b0;
        src_item    = '0;
        snk_stall   = 1'b0;
        in_taken    = 1'b0;
        quiet       = 1'b0;
        hold_asks   = 0;
        hold_served = 0;
        tx_gap      = 0;
        rx_gap      = 0;
        hold_left   = 0;
        idle_run    = 0;
        bad_count   = 0;
        opt         = '0;
        line_start  = 1'b1;
        blank_seen  = 1'b0;
        line_bcd    = '0;

        // reset options: bytes pass through untouched
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b0);
        offer(CH_TAB, 1'b0);
        offer(CH_NL, 1'b0);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // everything on except nonblank-only
        set_options(t_cfg'(6'b101111));
        offer(8'h41, 1'b1);
        offer(CH_NL, 1'b0);
        offer(CH_NL, 1'b0);         // kept blank line, numbered with dollar
        offer(CH_NL, 1'b0);         // squeezed, no output
        offer(CH_NL, 1'b0);
        offer(CH_TAB, 1'b0);
        offer(8'h00, 1'b0);
        offer(CH_DEL, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'hFF, 1'b0);
        offer(CH_HI_NL, 1'b0);      // M-^J starts a new line
        offer(8'h42, 1'b0);
        offer(8'h1F, 1'b0);
        offer(CH_NL, 1'b0);
        offer(8'h89, 1'b0);
        settle();

        // nonblank-only with show-ends: blank line gets padding, not a number
        set_options(t_cfg'(6'b111000));
        offer(CH_NL, 1'b0);
        offer(CH_NL, 1'b0);
        offer(8'h78, 1'b0);
        offer(CH_NL, 1'b0);
        settle();

        // nonblank-only alone numbers nothing
        set_options(t_cfg'(6'b010000));
        offer(CH_NL, 1'b0);
        offer(8'h79, 1'b0);
        offer(CH_NL, 1'b0);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: c = '1;
                1: c = '0;
                // many short numbered lines (75 to 150) so the counter can carry past 99
                2: c = t_cfg'({2'b10, 1'($urandom), 1'b0, 2'($urandom)});
                default: c = t_cfg'($urandom_range(0, 63));
            endcase
            set_options(c);
            if (ph == 7)
                quiet = 1'b1;
            if (ph == 2)
                queue_lines(150, 1, 0);
            else
                queue_lines(25, 8, 40);
            if (ph == 3)
                hold_asks++;
            settle();
        end

        if (bad_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
